// File: src/macd_pkg.sv
package macd_pkg;

    localparam int MAX_PERIOD = 64;
    localparam int PTR_W      = $clog2(MAX_PERIOD);
    localparam int PER_W      = 7;
    localparam int PRICE_W    = 32;
    localparam int VAL_W      = 32;
    localparam int FRAC_W     = 16;
    localparam int AVG_W      = PRICE_W + FRAC_W;
    localparam int SUM_W      = PRICE_W + PTR_W + 1;
    localparam int DIVD_W     = SUM_W - 1 + FRAC_W;
    localparam int DIV_CNT_W  = $clog2(DIVD_W + 1);
    localparam int ALPHA_SH   = 33;
    localparam int BAR_W      = 8;
    localparam int CNT_W      = 7;
    localparam int HCNT_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int OUT_BITS   = 2 + 1 + 3 * VAL_W;
    localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8;
    localparam int MUL_LAST   = 4;

    localparam logic [BAR_W-1:0]  BAR_MAX  = 8'd128;
    localparam logic [CNT_W-1:0]  CNT_MAX  = 7'd127;
    localparam logic [HCNT_W-1:0] HCNT_MAX = 2'd2;

    localparam logic [1:0] TRADE_NONE  = 2'd0;
    localparam logic [1:0] TRADE_LONG  = 2'd1;
    localparam logic [1:0] TRADE_SHORT = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FAST       = 3'd0,
        CFG_SLOW       = 3'd1,
        CFG_SIGNAL     = 3'd2,
        CFG_OVERBOUGHT = 3'd3,
        CFG_OVERSOLD   = 3'd4
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CHECK, ST_FAST, ST_SLOW, ST_SUM, ST_SUM_TAIL, ST_DIV_GO,
        ST_DIV_WAIT, ST_MUL, ST_WRITE, ST_MACD, ST_SIGCHK, ST_HIST, ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        JOB_FSEED, JOB_FEMA, JOB_SSEED, JOB_SEMA, JOB_SIG
    } job_t;

    typedef enum logic [1:0] {
        DIV_SEED, DIV_ALPHA, DIV_SIGNAL
    } div_mode_t;

    typedef struct packed {
        logic [PER_W-1:0]        fast_len;
        logic [PER_W-1:0]        slow_len;
        logic [PER_W-1:0]        sig_len;
        logic signed [VAL_W-1:0] overbought;
        logic signed [VAL_W-1:0] oversold;
    } cfg_t;

    typedef struct packed {
        logic             price_wr;
        logic             rd_en;
        logic             rd_macd;
        logic [PTR_W-1:0] rd_off;
        logic             div_start;
        div_mode_t        div_mode;
        logic [PER_W-1:0] n;
        logic             ema_en;
        logic [2:0]       ema_step;
        logic             tgt_slow;
        logic             fast_seed_wr;
        logic             fast_ema_wr;
        logic             slow_seed_wr;
        logic             slow_ema_wr;
        logic             signal_wr;
        logic             macd_wr;
        logic             hist_en;
        logic             have_hist;
        logic             out_load;
        logic             out_ind;
    } cmd_t;

    typedef struct packed {
        logic div_done;
    } sts_t;

    function automatic logic [PER_W-1:0] eff_period(input logic [PER_W-1:0] p);
        if (p == '0) return PER_W'(1);
        if (p > PER_W'(MAX_PERIOD)) return PER_W'(MAX_PERIOD);
        return p;
    endfunction

    function automatic logic [VAL_W-1:0] sat32(input logic [VAL_W:0] v);
        if (v[VAL_W] != v[VAL_W-1])
            return v[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
        return v[VAL_W-1:0];
    endfunction

endpackage

// File: src/macd_div.sv
module macd_div
    import macd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DIVD_W-1:0] dividend,
    input  logic [PER_W-1:0]  divisor,
    output logic [DIVD_W-1:0] quot,
    output logic              done
);

    // restoring divider, one quotient bit per cycle
    logic [DIVD_W-1:0]    quot_reg, quot_next;
    logic [PER_W:0]       rem_reg, rem_next;
    logic [PER_W-1:0]     dsr_reg;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [PER_W:0]       rem_sh;
    logic                 ge;

    assign rem_sh = {rem_reg[PER_W-1:0], quot_reg[DIVD_W-1]};
    assign ge     = rem_sh >= {1'b0, dsr_reg};

    always_comb begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quot_next = dividend;
            rem_next  = '0;
            cnt_next  = DIV_CNT_W'(DIVD_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quot_next = {quot_reg[DIVD_W-2:0], ge};
            rem_next  = ge ? rem_sh - {1'b0, dsr_reg} : rem_sh;
            cnt_next  = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        if (start) dsr_reg <= divisor;
    end

    assign quot = quot_reg;
    assign done = done_reg;

endmodule

// File: src/macd_dp.sv
module macd_dp
    import macd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  cfg_t               cfg,
    input  cmd_t               cmd,
    output sts_t               sts,
    input  logic [PRICE_W-1:0] s_price,
    output logic [OUT_W-1:0]   m_data
);

    logic [PRICE_W-1:0] price_mem [MAX_PERIOD];
    logic [VAL_W-1:0]   macd_mem  [MAX_PERIOD];

    logic [PTR_W-1:0]   price_wp_reg, macd_wp_reg;
    logic [PRICE_W-1:0] price_rd_reg, price_reg;
    logic [VAL_W-1:0]   macd_rd_reg;
    logic               rd_vld_reg, rd_first_reg, rd_macd_reg;
    logic [SUM_W-1:0]   sum_reg, rd_term;
    logic [AVG_W-1:0]   fast_reg, slow_reg, ema_reg, tgt, p48;
    logic [63:0]        prod_reg;
    logic [31:0]        mul_a, mul_b, beta;
    logic [VAL_W-1:0]   last_macd_reg, signal_reg, prev_hist_reg, hist_reg;
    logic [1:0]         trade_reg, trade_calc;
    logic [OUT_W-1:0]   out_reg;

    logic [DIVD_W-1:0]  dividend, quot;
    logic [PER_W-1:0]   divisor;
    logic               div_done;
    logic               sig_neg, alpha_one;
    logic [SUM_W-1:0]   sig_mag;
    logic [AVG_W:0]     avg_diff;
    logic [VAL_W-1:0]   macd_new, hist_new;
    logic [PTR_W-1:0]   price_rd_addr, macd_rd_addr;

    assign price_rd_addr = price_wp_reg - PTR_W'(1) - cmd.rd_off;
    assign macd_rd_addr  = macd_wp_reg - PTR_W'(1) - cmd.rd_off;

    // history memories
    always_ff @(posedge aclk) begin
        if (cmd.price_wr) price_mem[price_wp_reg] <= s_price;
        if (cmd.macd_wr) macd_mem[macd_wp_reg] <= macd_new;
        if (cmd.rd_en) begin
            price_rd_reg <= price_mem[price_rd_addr];
            macd_rd_reg  <= macd_mem[macd_rd_addr];
        end
    end

    assign rd_term = rd_macd_reg
                   ? {{(SUM_W-VAL_W){macd_rd_reg[VAL_W-1]}}, macd_rd_reg}
                   : {{(SUM_W-PRICE_W){1'b0}}, price_rd_reg};

    // divider operands
    assign sig_neg = sum_reg[SUM_W-1];
    assign sig_mag = sig_neg ? ~sum_reg : sum_reg;

    always_comb begin
        case (cmd.div_mode)
            DIV_ALPHA: begin
                dividend = DIVD_W'(1) << ALPHA_SH;
                divisor  = cmd.n + PER_W'(1);
            end
            DIV_SIGNAL: begin
                dividend = DIVD_W'(sig_mag[SUM_W-2:0]);
                divisor  = cmd.n;
            end
            default: begin
                dividend = {sum_reg[SUM_W-2:0], {FRAC_W{1'b0}}};
                divisor  = cmd.n;
            end
        endcase
    end

    macd_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .quot     (quot),
        .done     (div_done)
    );

    assign sts.div_done = div_done;

    // ema: alpha sits in the quotient after the alpha division
    assign alpha_one = quot[32];
    assign beta      = 32'({1'b1, 32'b0} - quot[32:0]);
    assign tgt       = cmd.tgt_slow ? slow_reg : fast_reg;
    assign p48       = {price_reg, {FRAC_W{1'b0}}};

    always_comb begin
        case (cmd.ema_step)
            3'd0: begin
                mul_a = {16'b0, price_reg[31:16]};
                mul_b = quot[31:0];
            end
            3'd1: begin
                mul_a = {price_reg[15:0], 16'b0};
                mul_b = quot[31:0];
            end
            3'd2: begin
                mul_a = {16'b0, tgt[47:32]};
                mul_b = beta;
            end
            3'd3: begin
                mul_a = tgt[31:0];
                mul_b = beta;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign avg_diff = {1'b0, fast_reg} - {1'b0, slow_reg};
    assign macd_new = sat32(avg_diff[AVG_W:FRAC_W]);
    assign hist_new = sat32({last_macd_reg[VAL_W-1], last_macd_reg}
                          - {signal_reg[VAL_W-1], signal_reg});

    always_comb begin
        if ($signed(prev_hist_reg) <= 0 && $signed(hist_new) > 0)
            trade_calc = TRADE_LONG;
        else if ($signed(prev_hist_reg) >= 0 && $signed(hist_new) < 0)
            trade_calc = TRADE_SHORT;
        else if ($signed(hist_new) > cfg.overbought)
            trade_calc = TRADE_SHORT;
        else if ($signed(hist_new) < cfg.oversold)
            trade_calc = TRADE_LONG;
        else
            trade_calc = TRADE_NONE;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            price_wp_reg  <= '0;
            macd_wp_reg   <= '0;
            rd_vld_reg    <= 1'b0;
            fast_reg      <= '0;
            slow_reg      <= '0;
            last_macd_reg <= '0;
            signal_reg    <= '0;
            prev_hist_reg <= '0;
        end else begin
            rd_vld_reg <= cmd.rd_en;
            if (cmd.price_wr) price_wp_reg <= price_wp_reg + PTR_W'(1);
            if (cmd.macd_wr) begin
                macd_wp_reg   <= macd_wp_reg + PTR_W'(1);
                last_macd_reg <= macd_new;
            end
            if (cmd.fast_seed_wr) fast_reg <= quot[AVG_W-1:0];
            if (cmd.fast_ema_wr)  fast_reg <= ema_reg;
            if (cmd.slow_seed_wr) slow_reg <= quot[AVG_W-1:0];
            if (cmd.slow_ema_wr)  slow_reg <= ema_reg;
            if (cmd.signal_wr)
                signal_reg <= sig_neg ? ~quot[VAL_W-1:0] : quot[VAL_W-1:0];
            if (cmd.hist_en) prev_hist_reg <= hist_new;
        end
    end

    always_ff @(posedge aclk) begin
        rd_first_reg <= cmd.rd_en && (cmd.rd_off == '0);
        rd_macd_reg  <= cmd.rd_macd;
        if (rd_vld_reg) sum_reg <= (rd_first_reg ? '0 : sum_reg) + rd_term;
        if (cmd.price_wr) begin
            price_reg <= s_price;
            hist_reg  <= '0;
            trade_reg <= TRADE_NONE;
        end
        if (cmd.hist_en) begin
            hist_reg  <= hist_new;
            trade_reg <= cmd.have_hist ? trade_calc : TRADE_NONE;
        end
        if (cmd.ema_en) begin
            prod_reg <= mul_a * mul_b;
            case (cmd.ema_step)
                3'd0: ema_reg <= alpha_one ? p48 : '0;
                3'd1: if (!alpha_one) ema_reg <= ema_reg + prod_reg[AVG_W-1:0];
                3'd2: if (!alpha_one) ema_reg <= ema_reg + AVG_W'(prod_reg[63:32]);
                3'd3: ema_reg <= ema_reg + prod_reg[AVG_W-1:0];
                default: ema_reg <= ema_reg + AVG_W'(prod_reg[63:32]);
            endcase
        end
        if (cmd.out_load)
            out_reg <= cmd.out_ind
                     ? {{(OUT_W-OUT_BITS){1'b0}}, hist_reg, signal_reg, last_macd_reg,
                        1'b1, trade_reg}
                     : '0;
    end

    assign m_data = out_reg;

endmodule

// File: src/macd_ctrl.sv
module macd_ctrl
    import macd_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  cfg_t cfg,
    input  logic s_tvalid,
    output logic s_tready,
    output logic m_tvalid,
    input  logic m_tready,
    output cmd_t cmd,
    input  sts_t sts
);

    state_t             state_reg, state_next;
    job_t               job_reg, job_next;
    logic [PER_W-1:0]   n_reg, n_next;
    logic [PTR_W-1:0]   cnt_reg, cnt_next;
    logic [BAR_W-1:0]   bar_reg, bar_next;
    logic [CNT_W-1:0]   avg_cnt_reg, avg_cnt_next;
    logic [CNT_W-1:0]   macd_cnt_reg, macd_cnt_next;
    logic [HCNT_W-1:0]  hcnt_reg, hcnt_next;
    logic               seeded_reg, seeded_next;
    logic               sig_seen_reg, sig_seen_next;
    logic               ind_reg, ind_next;
    logic               out_vld_reg, out_vld_next;
    logic [PER_W-1:0]   nf, ns, ng;
    logic               warm;

    assign nf   = eff_period(cfg.fast_len);
    assign ns   = eff_period(cfg.slow_len);
    assign ng   = eff_period(cfg.sig_len);
    assign warm = bar_reg < (BAR_W'(ns) + BAR_W'(ng));

    // next state
    always_comb begin
        state_next = state_reg;
        job_next   = job_reg;
        n_next     = n_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_tvalid) state_next = ST_CHECK;
            ST_CHECK: state_next = warm ? ST_DONE : ST_FAST;
            ST_FAST: begin
                n_next = nf;
                if (avg_cnt_reg != '0) begin
                    job_next   = JOB_FEMA;
                    state_next = ST_DIV_GO;
                end else if (bar_reg >= BAR_W'(nf)) begin
                    job_next   = JOB_FSEED;
                    state_next = ST_SUM;
                end else begin
                    state_next = ST_SLOW;
                end
            end
            ST_SLOW: begin
                n_next = ns;
                if (seeded_reg) begin
                    job_next   = JOB_SEMA;
                    state_next = ST_DIV_GO;
                end else if (bar_reg >= BAR_W'(ns)) begin
                    job_next   = JOB_SSEED;
                    state_next = ST_SUM;
                end else begin
                    state_next = ST_MACD;
                end
            end
            ST_SUM:      if (PER_W'(cnt_reg) == n_reg - PER_W'(1)) state_next = ST_SUM_TAIL;
            ST_SUM_TAIL: state_next = ST_DIV_GO;
            ST_DIV_GO:   state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (sts.div_done)
                    state_next = (job_reg == JOB_FEMA || job_reg == JOB_SEMA)
                               ? ST_MUL : ST_WRITE;
            end
            ST_MUL:      if (cnt_reg == PTR_W'(MUL_LAST)) state_next = ST_WRITE;
            ST_WRITE: begin
                unique case (job_reg)
                    JOB_FSEED, JOB_FEMA: state_next = ST_SLOW;
                    JOB_SSEED, JOB_SEMA: state_next = ST_MACD;
                    default:             state_next = ST_HIST;
                endcase
            end
            ST_MACD: state_next = ST_SIGCHK;
            ST_SIGCHK: begin
                if (macd_cnt_reg >= ng) begin
                    job_next   = JOB_SIG;
                    n_next     = ng;
                    state_next = ST_SUM;
                end else begin
                    state_next = ST_HIST;
                end
            end
            ST_HIST: state_next = ST_DONE;
            ST_DONE: if (!out_vld_reg || m_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd              = '0;
        cmd.price_wr     = (state_reg == ST_IDLE) && s_tvalid;
        cmd.rd_en        = (state_reg == ST_SUM);
        cmd.rd_macd      = (job_reg == JOB_SIG);
        cmd.rd_off       = cnt_reg;
        cmd.div_start    = (state_reg == ST_DIV_GO);
        cmd.n            = n_reg;
        cmd.ema_en       = (state_reg == ST_MUL);
        cmd.ema_step     = cnt_reg[2:0];
        cmd.tgt_slow     = (job_reg == JOB_SSEED || job_reg == JOB_SEMA);
        cmd.fast_seed_wr = (state_reg == ST_WRITE) && (job_reg == JOB_FSEED);
        cmd.fast_ema_wr  = (state_reg == ST_WRITE) && (job_reg == JOB_FEMA);
        cmd.slow_seed_wr = (state_reg == ST_WRITE) && (job_reg == JOB_SSEED);
        cmd.slow_ema_wr  = (state_reg == ST_WRITE) && (job_reg == JOB_SEMA);
        cmd.signal_wr    = (state_reg == ST_WRITE) && (job_reg == JOB_SIG);
        cmd.macd_wr      = (state_reg == ST_MACD) && (avg_cnt_reg >= ns);
        cmd.hist_en      = (state_reg == ST_HIST) && (macd_cnt_reg != '0) && sig_seen_reg;
        cmd.have_hist    = (hcnt_reg != '0);
        cmd.out_load     = (state_reg == ST_DONE) && (!out_vld_reg || m_tready);
        cmd.out_ind      = ind_reg;
        unique case (job_reg)
            JOB_FEMA, JOB_SEMA: cmd.div_mode = DIV_ALPHA;
            JOB_SIG:            cmd.div_mode = DIV_SIGNAL;
            default:            cmd.div_mode = DIV_SEED;
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_vld_reg;

    // counters and flags
    always_comb begin
        cnt_next      = (state_reg == ST_SUM || state_reg == ST_MUL)
                      ? cnt_reg + PTR_W'(1) : '0;
        bar_next      = bar_reg;
        avg_cnt_next  = avg_cnt_reg;
        seeded_next   = seeded_reg;
        macd_cnt_next = macd_cnt_reg;
        sig_seen_next = sig_seen_reg;
        hcnt_next     = hcnt_reg;
        ind_next      = ind_reg;
        out_vld_next  = out_vld_reg;
        if (cmd.price_wr && bar_reg < BAR_MAX) bar_next = bar_reg + BAR_W'(1);
        if (state_reg == ST_CHECK) ind_next = !warm;
        if (cmd.fast_seed_wr) avg_cnt_next = CNT_W'(1);
        if (cmd.fast_ema_wr && avg_cnt_reg < CNT_MAX) avg_cnt_next = avg_cnt_reg + CNT_W'(1);
        if (cmd.slow_seed_wr) seeded_next = 1'b1;
        if (cmd.macd_wr && macd_cnt_reg < CNT_MAX) macd_cnt_next = macd_cnt_reg + CNT_W'(1);
        if (cmd.signal_wr) sig_seen_next = 1'b1;
        if (cmd.hist_en && hcnt_reg < HCNT_MAX) hcnt_next = hcnt_reg + HCNT_W'(1);
        if (cmd.out_load) out_vld_next = 1'b1;
        else if (m_tready) out_vld_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            job_reg      <= JOB_FSEED;
            n_reg        <= '0;
            cnt_reg      <= '0;
            bar_reg      <= '0;
            avg_cnt_reg  <= '0;
            seeded_reg   <= 1'b0;
            macd_cnt_reg <= '0;
            sig_seen_reg <= 1'b0;
            hcnt_reg     <= '0;
            ind_reg      <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            job_reg      <= job_next;
            n_reg        <= n_next;
            cnt_reg      <= cnt_next;
            bar_reg      <= bar_next;
            avg_cnt_reg  <= avg_cnt_next;
            seeded_reg   <= seeded_next;
            macd_cnt_reg <= macd_cnt_next;
            sig_seen_reg <= sig_seen_next;
            hcnt_reg     <= hcnt_next;
            ind_reg      <= ind_next;
            out_vld_reg  <= out_vld_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!out_vld_reg || m_tready))
        else $error("result register overwritten while pending");

    a_hist_needs_signal: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.hist_en |-> (sig_seen_reg && macd_cnt_reg != '0))
        else $error("histogram without signal line");

    a_accept_to_check: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_CHECK))
        else $error("accepted bar not processed");

    a_bar_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        bar_reg <= BAR_MAX)
        else $error("bar count beyond saturation");
`endif

endmodule

// File: src/macd_crossover_signal.sv
// Channel  | Dir | Payload (low bits first)                                  | Handshake
// s_       | in  | tdata[31:0] close_price                                   | s_tvalid/s_tready
// m_       | out | trade_signal, indicators_valid, macd, signal, histogram  | m_tvalid/m_tready
// cfg_     | in  | cfg_index (register), cfg_data                            | cfg_valid/cfg_ready
//
// One bar at a time. A warm-up bar only stores its price. A bar on running EMAs runs an EMA
// update for each average (an alpha division plus 5 multiply steps), and recomputes the
// signal line over its N-entry MACD history once that history holds N entries.
// A seeding job walks the N-entry price history and divides, in place of an EMA update.
// All jobs share one 54-step bit-serial divider.
// Reset is synchronous, active low; no memory clearing pass is needed.
// A finished result waits in the output register; the next bar is taken meanwhile,
// and its own result holds the sequencer until the pending one is transferred.
module macd_crossover_signal
    import macd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [PRICE_W-1:0]   s_tdata,     // [31:0] close_price
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [OUT_W-1:0]     m_tdata,     // [1:0] trade_signal, [2] indicators_valid,
                                              // [34:3] macd_value, [66:35] signal_value,
                                              // [98:67] histogram_value, rest zero
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [VAL_W-1:0]     cfg_data
);

    cfg_t cfg_reg;
    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    // configuration registers; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.fast_len   <= PER_W'(12);
            cfg_reg.slow_len   <= PER_W'(26);
            cfg_reg.sig_len    <= PER_W'(9);
            cfg_reg.overbought <= {1'b0, {(VAL_W-1){1'b1}}};
            cfg_reg.oversold   <= {1'b1, {(VAL_W-1){1'b0}}};
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_FAST:       cfg_reg.fast_len   <= cfg_data[PER_W-1:0];
                CFG_SLOW:       cfg_reg.slow_len   <= cfg_data[PER_W-1:0];
                CFG_SIGNAL:     cfg_reg.sig_len    <= cfg_data[PER_W-1:0];
                CFG_OVERBOUGHT: cfg_reg.overbought <= cfg_data;
                CFG_OVERSOLD:   cfg_reg.oversold   <= cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer: warm-up check, seed/EMA jobs, MACD, signal line, histogram
    macd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // histories, accumulators, multiplier, divider and result register
    macd_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .cmd      (cmd),
        .sts      (sts),
        .s_price  (s_tdata),
        .m_data   (m_tdata)
    );

endmodule

// File: verif/macd_checker.sv
`timescale 1ns / 1ps

module macd_checker
    import macd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [PRICE_W-1:0]   s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [OUT_W-1:0]     m_tdata,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [VAL_W-1:0]     cfg_data,
    output int                   fail_count,
    output int                   pending_bars,
    output int                   bars_seen,
    output int                   trades_seen
);

    // highest field first, so trade lands in the low bits as on m_tdata
    typedef struct packed {
        logic signed [VAL_W-1:0] hist;
        logic signed [VAL_W-1:0] sig;
        logic signed [VAL_W-1:0] macd;
        logic                    valid;
        logic [1:0]              trade;
    } bar_result_t;

    bar_result_t expected_bars[$];

    logic [PER_W-1:0] fast_n, slow_n, sig_n;
    longint           ob_lvl, os_lvl;
    logic [31:0]      prices[MAX_PERIOD];
    longint           macds[MAX_PERIOD];
    int               p_wp, m_wp, n_bars, fast_cnt, m_cnt, h_cnt;
    bit               slow_ok, sig_ok;
    longint unsigned  fast_avg, slow_avg;
    longint           cur_sig, prev_h;

    function automatic int clamp_period(logic [PER_W-1:0] p);
        if (p == 0) return 1;
        if (p > MAX_PERIOD) return MAX_PERIOD;
        return int'(p);
    endfunction

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint floor_quot(longint s, longint d);
        longint q;
        q = s / d;
        if ((s % d) != 0 && s < 0) q--;
        return q;
    endfunction

    function automatic longint unsigned scale_q32(longint unsigned a, longint unsigned b);
        if (b >= 64'h1_0000_0000) return a;
        return (a >> 32) * b + (((a & 64'hFFFF_FFFF) * b) >> 32);
    endfunction

    function automatic longint unsigned window_mean(int n);
        longint unsigned sum;
        sum = 0;
        for (int i = 0; i < n; i++)
            sum += prices[(p_wp + MAX_PERIOD - 1 - i) % MAX_PERIOD];
        return (sum << 16) / n;
    endfunction

    function automatic longint unsigned ema_next(longint unsigned avg, logic [31:0] p, int n);
        longint unsigned alpha;
        alpha = 64'h2_0000_0000 / (n + 1);
        return scale_q32(longint'(p) << 16, alpha) + scale_q32(avg, 64'h1_0000_0000 - alpha);
    endfunction

    function automatic bar_result_t predict_bar(logic [31:0] price);
        bar_result_t r;
        int nf, ns, ng;
        longint m, h, pv, sum;
        bit have_h;
        nf = clamp_period(fast_n);
        ns = clamp_period(slow_n);
        ng = clamp_period(sig_n);
        r = '0;
        m = 0; h = 0;
        prices[p_wp] = price;
        p_wp = (p_wp + 1) % MAX_PERIOD;
        if (n_bars < 128) n_bars++;
        if (n_bars < ns + ng) return r;
        if (fast_cnt == 0) begin
            if (n_bars >= nf) begin
                fast_avg = window_mean(nf);
                fast_cnt = 1;
            end
        end else begin
            fast_avg = ema_next(fast_avg, price, nf);
            if (fast_cnt < 127) fast_cnt++;
        end
        if (!slow_ok) begin
            if (n_bars >= ns) begin
                slow_avg = window_mean(ns);
                slow_ok = 1;
            end
        end else begin
            slow_avg = ema_next(slow_avg, price, ns);
        end
        if (fast_cnt >= ns) begin
            macds[m_wp] = clip32(floor_quot(longint'(fast_avg) - longint'(slow_avg), 65536));
            m_wp = (m_wp + 1) % MAX_PERIOD;
            if (m_cnt < 127) m_cnt++;
        end
        if (m_cnt > 0) m = macds[(m_wp + MAX_PERIOD - 1) % MAX_PERIOD];
        if (m_cnt >= ng) begin
            sum = 0;
            for (int i = 0; i < ng; i++)
                sum += macds[(m_wp + MAX_PERIOD - 1 - i) % MAX_PERIOD];
            cur_sig = floor_quot(sum, ng);
            sig_ok = 1;
        end
        if (m_cnt > 0 && sig_ok) begin
            h = clip32(m - cur_sig);
            pv = prev_h;
            have_h = h_cnt >= 1;
            if (h_cnt < 2) h_cnt++;
            prev_h = h;
            if (have_h) begin
                if (pv <= 0 && h > 0) r.trade = TRADE_LONG;
                else if (pv >= 0 && h < 0) r.trade = TRADE_SHORT;
                else if (h > ob_lvl) r.trade = TRADE_SHORT;
                else if (h < os_lvl) r.trade = TRADE_LONG;
            end
        end
        r.valid = 1'b1;
        r.macd = m[31:0];
        r.sig = cur_sig[31:0];
        r.hist = h[31:0];
        return r;
    endfunction

    bar_result_t got, want;

    always @(posedge aclk) begin
        if (!aresetn) begin
            fast_n = PER_W'(12); slow_n = PER_W'(26); sig_n = PER_W'(9);
            ob_lvl = 64'sd2147483647; os_lvl = -64'sd2147483648;
            p_wp = 0; m_wp = 0; n_bars = 0; fast_cnt = 0; m_cnt = 0; h_cnt = 0;
            slow_ok = 0; sig_ok = 0; fast_avg = 0; slow_avg = 0;
            cur_sig = 0; prev_h = 0;
            expected_bars.delete();
            fail_count <= 0; pending_bars <= 0; bars_seen <= 0; trades_seen <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_FAST:       fast_n = cfg_data[PER_W-1:0];
                    CFG_SLOW:       slow_n = cfg_data[PER_W-1:0];
                    CFG_SIGNAL:     sig_n = cfg_data[PER_W-1:0];
                    CFG_OVERBOUGHT: ob_lvl = longint'($signed(cfg_data));
                    CFG_OVERSOLD:   os_lvl = longint'($signed(cfg_data));
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                expected_bars.insert(expected_bars.size(), predict_bar(s_tdata));
                bars_seen <= bars_seen + 1;
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[OUT_BITS-1:0];
                if (expected_bars.size() == 0) begin
                    $error("result transfer with no bar outstanding");
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_bars.pop_front();
                    if (got.trade != TRADE_NONE) trades_seen <= trades_seen + 1;
                    if (got.trade != want.trade)
                        $error("trade_signal exp %0d got %0d", want.trade, got.trade);
                    if (got.valid != want.valid)
                        $error("indicators_valid exp %0d got %0d", want.valid, got.valid);
                    if (got.macd != want.macd)
                        $error("macd_value exp %0d got %0d", want.macd, got.macd);
                    if (got.sig != want.sig)
                        $error("signal_value exp %0d got %0d", want.sig, got.sig);
                    if (got.hist != want.hist)
                        $error("histogram_value exp %0d got %0d", want.hist, got.hist);
                    if (got != want) fail_count <= fail_count + 1;
                end
            end
            pending_bars <= expected_bars.size();
        end
    end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import macd_pkg::*;

    localparam longint CYCLE_LIMIT = 64'd3_000_000;

    logic                 aclk = 0;
    logic                 aresetn = 0;
    logic                 s_tvalid = 0;
    logic                 s_tready;
    logic [PRICE_W-1:0]   s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 0;
    logic [OUT_W-1:0]     m_tdata;
    logic                 cfg_valid = 0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [VAL_W-1:0]     cfg_data = '0;

    int     fail_count, pending_bars, bars_seen, trades_seen;
    bit     quiet_tail = 0;   // no idling on either side near the end
    longint cycles = 0;
    logic [31:0] base_price;

    always #5 aclk = ~aclk;

    macd_crossover_signal uut (.*);

    macd_checker chk (.*);

    // hard stop in case the block hangs
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result side: random stall bursts, then ready held high
    initial begin
        @(posedge aclk iff aresetn);
        forever begin
            if (!quiet_tail && $urandom_range(0, 3) == 0) begin
                m_tready <= 0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
            end
            m_tready <= 1;
            repeat ($urandom_range(1, 30)) @(posedge aclk);
        end
    end

    task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk iff cfg_ready);
        cfg_valid <= 0;
    endtask

    task automatic send_bar(logic [31:0] price);
        if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata  <= price;
        @(posedge aclk iff s_tready);
    endtask

    // lets the pipe empty, including the block's own trailing work
    task automatic drain();
        s_tvalid <= 0;
        @(posedge aclk);
        while (pending_bars != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    task automatic set_periods(int f, int sl, int sg, logic [31:0] ob, logic [31:0] os);
        write_reg(CFG_FAST, f);
        write_reg(CFG_SLOW, sl);
        write_reg(CFG_SIGNAL, sg);
        write_reg(CFG_OVERBOUGHT, ob);
        write_reg(CFG_OVERSOLD, os);
    endtask

    // random walk with occasional jumps, so the histogram crosses zero often
    function automatic logic [31:0] next_price(logic [31:0] p);
        case ($urandom_range(0, 19))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom;
            default: return p + $urandom_range(0, 32'h4_0000) - 32'h2_0000;
        endcase
    endfunction

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: default periods, price extremes, with a hold-off until empty
        send_bar(32'h0);
        send_bar(32'hFFFF_FFFF);
        send_bar(32'h0);
        send_bar(32'hFFFF_FFFF);
        drain();
        // shortest periods: EMA and signal on almost every bar, extremes alternate
        set_periods(1, 1, 1, 32'h0, 32'h0);
        for (int i = 0; i < 8; i++) send_bar(i[0] ? 32'hFFFF_FFFF : 32'h0);
        drain();

        // random phases over several settings, out-of-range periods included
        for (int ph = 0; ph < 10; ph++) begin
            // every phase carries on from the state the last one left, with no reset; periods kept small mostly
            case (ph)
                0: set_periods(0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000);
                1: set_periods(64, 64, 64, 32'h0001_0000, 32'hFFFF_0000);
                2: set_periods(127, 100, 65, 32'h0, 32'h0);
                default: set_periods($urandom_range(1, 12), $urandom_range(1, 16),
                                     $urandom_range(1, 8), $urandom, $urandom);
            endcase
            base_price = $urandom_range(32'h10_0000, 32'h7000_0000);
            for (int i = 0; i < 70; i++) begin
                if (ph == 9 && i == 40) quiet_tail = 1;
                base_price = next_price(base_price);
                send_bar(base_price);
            end
            if (ph != 9) drain();
        end
        s_tvalid <= 0;

        @(posedge aclk);
        while (pending_bars != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);

        $display("Sent %0d bars over twelve period/threshold settings; %0d trade signals seen.",
                 bars_seen, trades_seen);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
